// ===== design/i8rq_pkg.sv =====
// Package for the int8 per-channel requantisation block.
// Holds the int8 clamp limits and the special-case result codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package i8rq_pkg;

	localparam logic signed [31:0] QNT_MIN = -32'sd128;
	localparam logic signed [31:0] QNT_MAX = 32'sd127;

	// Outcome of the special-case checks on scale and accumulator
	typedef enum logic [1:0] {
		KIND_NORMAL = 2'd0,
		KIND_ZERO   = 2'd1,
		KIND_MAXPOS = 2'd2,
		KIND_SAT    = 2'd3
	} kind_t;

endpackage
`default_nettype wire

// ===== design/int8_per_channel_requantize_relu.sv =====
// Top level of the int8 per-channel requantisation block with optional ReLU.
// Uses i8rq_pkg for clamp limits and special-case codes.
// The result strobe done is registered behind the valid registers v_s1, v_s2, v_s3 and v_s4.
// Throughput: one beat per cycle; busy is never raised, as each stage holds one item.
// The 24 by 24 bit significand multiplier sets the middle stage; the receiver cannot stall.
// Reset clears the stage valid bits and the activation mode register.
`timescale 1ns / 1ps
`default_nettype none
module int8_per_channel_requantize_relu
	import i8rq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] accumulator,
	input  wire logic        [31:0] scale_bits,
	input  wire logic signed [31:0] zero_point,
	input  wire logic               chunk_last,
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata,
	output logic                    done,
	output logic signed [7:0]       quantized,
	output logic                    last
);

	logic mode_q;
	logic v_s1, v_s2, v_s3, v_s4;

	// Stage 1: input register
	logic [31:0] acc_s1, sb_s1, zp_s1;
	logic        last_s1;

	// Stage 2: accumulator as single precision
	logic [23:0] sa_s2;
	logic [5:0]  ea_s2;
	logic        neg_s2, last_s2;
	logic [7:0]  sexp_s2;
	logic [22:0] sfrac_s2;
	kind_t       kind_s2;
	logic [31:0] zp_s2;

	// Stage 3: raw product
	logic [47:0] prod_s3;
	logic signed [9:0] e_s3;
	logic        neg_s3, last_s3;
	kind_t       kind_s3;
	logic [31:0] zp_s3;

	// Stage 4: rounded product
	logic [23:0] sig_s4;
	logic signed [9:0] e_s4;
	logic        neg_s4, last_s4;
	kind_t       kind_s4;
	logic [31:0] zp_s4;

	assign busy = 1'b0;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			done <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		acc_s1  <= accumulator;
		sb_s1   <= scale_bits;
		zp_s1   <= zero_point;
		last_s1 <= chunk_last;
	end

	// Magnitude, special cases and normalisation of the accumulator
	logic [31:0] mag_a, norm_a;
	logic [4:0]  p_a;
	logic        inc_a;
	logic [24:0] rnd_a;
	logic        neg_a;
	kind_t       kind_a;

	always_comb begin
		mag_a = acc_s1[31] ? (32'd0 - acc_s1) : acc_s1;
		neg_a = acc_s1[31] ^ sb_s1[31];
		p_a = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (mag_a[i]) p_a = 5'(i);
		end
		norm_a = mag_a << (5'd31 - p_a);
		inc_a = norm_a[7] && ((|norm_a[6:0]) || norm_a[8]);
		rnd_a = {1'b0, norm_a[31:8]} + {24'd0, inc_a};
		if (sb_s1[30:23] == 8'hFF) begin
			kind_a = ((|sb_s1[22:0]) || (mag_a == 32'd0)) ? KIND_MAXPOS : KIND_SAT;
		end else if (sb_s1[30:23] == 8'd0 || mag_a == 32'd0) begin
			kind_a = KIND_ZERO;
		end else begin
			kind_a = KIND_NORMAL;
		end
	end

	always_ff @(posedge clk) begin
		sa_s2    <= rnd_a[24] ? 24'h800000 : rnd_a[23:0];
		ea_s2    <= {1'b0, p_a} + {5'd0, rnd_a[24]};
		neg_s2   <= neg_a;
		sexp_s2  <= sb_s1[30:23];
		sfrac_s2 <= sb_s1[22:0];
		kind_s2  <= kind_a;
		zp_s2    <= zp_s1;
		last_s2  <= last_s1;
	end

	// Significand product and exponent sum
	always_ff @(posedge clk) begin
		prod_s3 <= 48'(sa_s2) * 48'({1'b1, sfrac_s2});
		e_s3    <= $signed({4'd0, ea_s2}) + $signed({2'd0, sexp_s2}) - 10'sd127;
		neg_s3  <= neg_s2;
		kind_s3 <= kind_s2;
		zp_s3   <= zp_s2;
		last_s3 <= last_s2;
	end

	// Round the product to 24 bits
	logic [23:0] keep_c;
	logic        g_c, st_c;
	logic [24:0] rnd_c;
	logic signed [9:0] e_c;

	always_comb begin
		if (prod_s3[47]) begin
			keep_c = prod_s3[47:24];
			g_c    = prod_s3[23];
			st_c   = |prod_s3[22:0];
			e_c    = e_s3 + 10'sd1;
		end else begin
			keep_c = prod_s3[46:23];
			g_c    = prod_s3[22];
			st_c   = |prod_s3[21:0];
			e_c    = e_s3;
		end
		rnd_c = {1'b0, keep_c} + {24'd0, g_c && (st_c || keep_c[0])};
	end

	always_ff @(posedge clk) begin
		sig_s4  <= rnd_c[24] ? 24'h800000 : rnd_c[23:0];
		e_s4    <= rnd_c[24] ? e_c + 10'sd1 : e_c;
		neg_s4  <= neg_s3;
		kind_s4 <= kind_s3;
		zp_s4   <= zp_s3;
		last_s4 <= last_s3;
	end

	// Conversion to int32, zero point, clamp and ReLU
	logic [31:0] iv_d, r_d, sum_d;
	logic [4:0]  sh_d;
	logic [24:0] q_d, rem_d, half_d;
	logic signed [31:0] v_d;
	logic [7:0]  res_d;

	always_comb begin
		sh_d   = 5'(10'sd23 - e_s4);
		q_d    = {1'b0, sig_s4} >> sh_d;
		rem_d  = {1'b0, sig_s4} & ((25'd1 << sh_d) - 25'd1);
		half_d = 25'd1 << (sh_d - 5'd1);
		if (rem_d > half_d || (rem_d == half_d && q_d[0])) q_d = q_d + 25'd1;
		if (e_s4 >= 10'sd23) begin
			iv_d = {8'd0, sig_s4} << 5'(e_s4 - 10'sd23);
		end else begin
			iv_d = {7'd0, q_d};
		end
		case (kind_s4)
			KIND_ZERO:   r_d = 32'd0;
			KIND_MAXPOS: r_d = 32'h7FFFFFFF;
			KIND_SAT:    r_d = neg_s4 ? 32'h80000000 : 32'h7FFFFFFF;
			default: begin
				if (e_s4 >= 10'sd31) begin
					r_d = neg_s4 ? 32'h80000000 : 32'h7FFFFFFF;
				end else if (e_s4 < -10'sd1) begin
					r_d = 32'd0;
				end else begin
					r_d = neg_s4 ? (32'd0 - iv_d) : iv_d;
				end
			end
		endcase
		sum_d = r_d + zp_s4;
		v_d = $signed(sum_d);
		if (v_d < QNT_MIN) v_d = QNT_MIN;
		if (v_d > QNT_MAX) v_d = QNT_MAX;
		if (mode_q && v_d < 32'sd0) v_d = 32'sd0;
		res_d = v_d[7:0];
	end

	always_ff @(posedge clk) begin
		quantized <= $signed(res_d);
		last      <= last_s4;
	end

endmodule
`default_nettype wire
